[src/ffha_pkg.sv]
// Shared constants, codes and types of the first-fit heap allocator.
package ffha_pkg;

	localparam int HEADER_BYTES  = 8;
	localparam int HDR_SHIFT     = $clog2(HEADER_BYTES);
	localparam int HEAP_GRANULES = 65536;
	localparam int GROW_GRANULES = 1024;
	localparam int FREE_ENTRIES  = 64;

	localparam int GRAN_W = $clog2(HEAP_GRANULES);
	localparam int SIZE_W = GRAN_W + 1;
	localparam int HDR_W  = SIZE_W + 1;
	localparam int TIDX_W = $clog2(FREE_ENTRIES);
	localparam int CNT_W  = TIDX_W + 1;
	localparam int GR_W   = 18;
	localparam int ADDR_W = 19;
	localparam int BYTES_W = 20;

	localparam logic [1:0] MODE_ALLOC    = 2'd0;
	localparam logic [1:0] MODE_FREE     = 2'd1;
	localparam logic [1:0] MODE_COALESCE = 2'd2;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_ZERO     = 3'd1;
	localparam logic [2:0] ST_NOMEM    = 3'd2;
	localparam logic [2:0] ST_BAD_FREE = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;

	typedef struct packed {
		logic [SIZE_W-1:0] size;
		logic [GRAN_W-1:0] start;
	} fent_t;

endpackage

[src/first_fit_heap_allocator_top.sv]
// Top level of the first-fit heap allocator: sequencer around header and free-table RAMs.
//
// Input channel s_*: one request per transfer (allocate, free or coalesce).
// Output channel m_*: exactly one result per request, in request order.
// Configuration: cfg_wr_en with cfg_wr_data sets the heap limit in granules.
// After reset the header RAM is swept to clear all live marks, one granule
// per cycle, so s_tready stays low until the sweep is done.
// A request walks the free table one entry at a time, and every table step is a
// read of the single-port-read table RAM followed in the next state by a check
// of the entry read or a write.
// One request is in work at a time. The result sits in an output register;
// while the receiver stalls, one more request is accepted and worked on, and
// its result then waits until the output register has been handed over.
module first_fit_heap_allocator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // mode[1:0], request_bytes[21:2], free_address[40:22]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // status[2:0], payload_address[21:3], free_entries[28:22]
	input  logic        cfg_wr_en,
	input  logic [16:0] cfg_wr_data
);

	localparam int GW = ffha_pkg::GRAN_W;
	localparam int SW = ffha_pkg::SIZE_W;
	localparam int CW = ffha_pkg::CNT_W;
	localparam int TW = ffha_pkg::TIDX_W;
	localparam int RW = ffha_pkg::GR_W;

	localparam logic [4:0] S_CLEAR    = 5'd0;
	localparam logic [4:0] S_IDLE     = 5'd1;
	localparam logic [4:0] S_SCAN_RD  = 5'd2;
	localparam logic [4:0] S_SCAN_CHK = 5'd3;
	localparam logic [4:0] S_RM       = 5'd4;
	localparam logic [4:0] S_RM_WR    = 5'd5;
	localparam logic [4:0] S_AL_MARK  = 5'd6;
	localparam logic [4:0] S_GROW     = 5'd7;
	localparam logic [4:0] S_INS      = 5'd8;
	localparam logic [4:0] S_INS_H    = 5'd9;
	localparam logic [4:0] S_INS_RD   = 5'd10;
	localparam logic [4:0] S_INS_CHK  = 5'd11;
	localparam logic [4:0] S_SH       = 5'd12;
	localparam logic [4:0] S_SH_WR    = 5'd13;
	localparam logic [4:0] S_FREE_CHK = 5'd14;
	localparam logic [4:0] S_CO_LD    = 5'd15;
	localparam logic [4:0] S_CO_RD    = 5'd16;
	localparam logic [4:0] S_CO_CHK   = 5'd17;
	localparam logic [4:0] S_DONE     = 5'd18;

	localparam logic RET_ALLOC = 1'b0;
	localparam logic RET_COAL  = 1'b1;

	localparam logic [CW-1:0] TABLE_FULL = CW'(ffha_pkg::FREE_ENTRIES);
	localparam logic [RW-1:0] GROW_MIN   = RW'(ffha_pkg::GROW_GRANULES);
	localparam logic [SW-1:0] HEAP_MAX   = SW'(ffha_pkg::HEAP_GRANULES);

	logic [4:0]    state_q;
	logic [GW-1:0] clr_q;
	logic [CW-1:0] cnt_q;
	logic [SW-1:0] brk_q;
	logic [SW-1:0] lim_q;
	logic [RW-1:0] gr_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] rk_q;
	logic [CW-1:0] pos_q;
	logic          ret_q;
	ffha_pkg::fent_t cur_q;
	ffha_pkg::fent_t ins_q;
	logic [2:0]    status_q;
	logic [ffha_pkg::ADDR_W-1:0] addr_q;

	logic          m_tvalid_q;
	logic [2:0]    out_status_q;
	logic [ffha_pkg::ADDR_W-1:0] out_addr_q;
	logic [CW-1:0] out_cnt_q;

	// RAM ports.
	logic                      t_we;
	logic [TW-1:0]             t_waddr, t_raddr;
	ffha_pkg::fent_t           t_wdata, t_rdata;
	logic                      h_we;
	logic [GW-1:0]             h_waddr, h_raddr;
	logic [ffha_pkg::HDR_W-1:0] h_wdata, h_rdata;

	// Request decode.
	logic [1:0]    in_mode;
	logic [ffha_pkg::BYTES_W-1:0] in_bytes;
	logic [ffha_pkg::ADDR_W-1:0]  in_faddr;
	logic [ffha_pkg::BYTES_W:0]   need;
	logic [RW-1:0] in_gr;
	logic [GW-1:0] in_g;
	logic          free_bad;
	logic          accept;

	assign in_mode  = s_tdata[1:0];
	assign in_bytes = s_tdata[21:2];
	assign in_faddr = s_tdata[40:22];
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		need = {1'b0, in_bytes} + (ffha_pkg::BYTES_W + 1)'(ffha_pkg::HEADER_BYTES);
		if (need < (ffha_pkg::BYTES_W + 1)'(2 * ffha_pkg::HEADER_BYTES)) begin
			need = (ffha_pkg::BYTES_W + 1)'(2 * ffha_pkg::HEADER_BYTES);
		end
		in_gr = RW'((need + (ffha_pkg::BYTES_W + 1)'(ffha_pkg::HEADER_BYTES - 1))
			>> ffha_pkg::HDR_SHIFT);
	end

	assign in_g = in_faddr[ffha_pkg::ADDR_W-1:ffha_pkg::HDR_SHIFT] - GW'(1);
	assign free_bad = (in_faddr == '0) || (in_faddr[ffha_pkg::HDR_SHIFT-1:0] != '0)
		|| ({1'b0, in_g} >= brk_q);

	// Growth arithmetic.
	logic [RW-1:0] grow;
	logic [SW-1:0] lim_eff;
	logic [RW:0]   new_brk;
	assign grow    = (gr_q > GROW_MIN) ? gr_q : GROW_MIN;
	assign lim_eff = (lim_q > HEAP_MAX) ? HEAP_MAX : lim_q;
	assign new_brk = (RW + 1)'(brk_q) + (RW + 1)'(grow);

	// Coalesce arithmetic.
	logic [SW:0] end0, end1, emax;
	assign end0 = (SW + 1)'(cur_q.start) + (SW + 1)'(cur_q.size);
	assign end1 = (SW + 1)'(t_rdata.start) + (SW + 1)'(t_rdata.size);
	assign emax = (end1 > end0) ? end1 : end0;

	logic merge;
	assign merge = end0 >= (SW + 1)'(t_rdata.start);

	ffha_pkg::fent_t merged;
	assign merged.start = cur_q.start;
	assign merged.size  = SW'(emax - (SW + 1)'(cur_q.start));

	function automatic logic [ffha_pkg::ADDR_W-1:0] gran_addr(input logic [GW-1:0] g);
		logic [SW-1:0] g1;
		g1 = {1'b0, g} + SW'(1);
		return {g1[GW-1:0], {ffha_pkg::HDR_SHIFT{1'b0}}};
	endfunction

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, out_cnt_q, out_addr_q, out_status_q};

	// RAM port control.
	always_comb begin
		t_we    = 1'b0;
		t_waddr = '0;
		t_wdata = t_rdata;
		t_raddr = '0;
		h_we    = 1'b0;
		h_waddr = '0;
		h_wdata = '0;
		h_raddr = in_g;
		unique case (state_q)
			S_CLEAR: begin
				h_we    = 1'b1;
				h_waddr = clr_q;
			end
			S_IDLE: begin
				t_raddr = '0;
			end
			S_SCAN_RD: begin
				t_raddr = idx_q[TW-1:0];
			end
			S_RM: begin
				t_raddr = TW'(rk_q + CW'(1));
			end
			S_RM_WR: begin
				t_we    = 1'b1;
				t_waddr = rk_q[TW-1:0];
			end
			S_AL_MARK: begin
				h_we    = 1'b1;
				h_waddr = cur_q.start;
				h_wdata = {1'b1, gr_q[SW-1:0]};
			end
			S_GROW: begin
				h_we    = (new_brk <= (RW + 1)'(lim_eff));
				h_waddr = brk_q[GW-1:0];
				h_wdata = {1'b1, gr_q[SW-1:0]};
			end
			S_INS: begin
				t_raddr = '0;
			end
			S_INS_RD: begin
				t_raddr = idx_q[TW-1:0];
			end
			S_SH: begin
				t_raddr = TW'(idx_q - CW'(1));
				if (idx_q <= pos_q) begin
					t_we    = 1'b1;
					t_waddr = pos_q[TW-1:0];
					t_wdata = ins_q;
				end
			end
			S_SH_WR: begin
				t_we    = 1'b1;
				t_waddr = idx_q[TW-1:0];
			end
			S_FREE_CHK: begin
				h_we    = h_rdata[ffha_pkg::HDR_W-1] && (cnt_q != TABLE_FULL);
				h_waddr = cur_q.start;
				h_wdata = {1'b0, h_rdata[SW-1:0]};
			end
			S_CO_RD: begin
				t_raddr = TW'(idx_q + CW'(1));
			end
			S_CO_CHK: begin
				t_we    = merge;
				t_waddr = idx_q[TW-1:0];
				t_wdata = merged;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			cnt_q        <= '0;
			brk_q        <= '0;
			lim_q        <= HEAP_MAX;
			m_tvalid_q   <= 1'b0;
			idx_q        <= '0;
			rk_q         <= '0;
			pos_q        <= '0;
			ret_q        <= RET_ALLOC;
		end else begin
			if (cfg_wr_en) begin
				lim_q <= cfg_wr_data;
			end
			// The done state reloads the output register itself.
			if (m_tvalid_q && m_tready && (state_q != S_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + GW'(1);
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						addr_q   <= '0;
						gr_q     <= in_gr;
						idx_q    <= '0;
						cur_q.start <= in_g;
						unique case (in_mode)
							ffha_pkg::MODE_ALLOC: begin
								if (in_bytes == '0) begin
									status_q <= ffha_pkg::ST_ZERO;
									state_q  <= S_DONE;
								end else if (cnt_q == '0) begin
									status_q <= ffha_pkg::ST_OK;
									state_q  <= S_GROW;
								end else begin
									status_q <= ffha_pkg::ST_OK;
									state_q  <= S_SCAN_RD;
								end
							end
							ffha_pkg::MODE_FREE: begin
								if (free_bad) begin
									status_q <= ffha_pkg::ST_BAD_FREE;
									state_q  <= S_DONE;
								end else begin
									status_q <= ffha_pkg::ST_OK;
									state_q  <= S_FREE_CHK;
								end
							end
							ffha_pkg::MODE_COALESCE: begin
								status_q <= ffha_pkg::ST_OK;
								state_q  <= (cnt_q > CW'(1)) ? S_CO_LD : S_DONE;
							end
							default: begin
								status_q <= ffha_pkg::ST_OK;
								state_q  <= S_DONE;
							end
						endcase
					end
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN_CHK;
				end
				S_SCAN_CHK: begin
					if (RW'(t_rdata.size) >= gr_q) begin
						cur_q   <= t_rdata;
						rk_q    <= idx_q;
						ret_q   <= RET_ALLOC;
						state_q <= S_RM;
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= (idx_q + CW'(1) == cnt_q) ? S_GROW : S_SCAN_RD;
					end
				end
				S_RM: begin
					if (rk_q + CW'(1) < cnt_q) begin
						state_q <= S_RM_WR;
					end else begin
						cnt_q   <= cnt_q - CW'(1);
						state_q <= (ret_q == RET_COAL) ? S_CO_RD : S_AL_MARK;
					end
				end
				S_RM_WR: begin
					rk_q    <= rk_q + CW'(1);
					state_q <= S_RM;
				end
				S_AL_MARK: begin
					addr_q <= gran_addr(cur_q.start);
					if (RW'(cur_q.size) > gr_q) begin
						ins_q.start <= GW'({1'b0, cur_q.start} + SW'(gr_q));
						ins_q.size  <= SW'(RW'(cur_q.size) - gr_q);
						state_q     <= S_INS;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_GROW: begin
					if (new_brk > (RW + 1)'(lim_eff)) begin
						status_q <= ffha_pkg::ST_NOMEM;
						state_q  <= S_DONE;
					end else begin
						addr_q <= gran_addr(brk_q[GW-1:0]);
						brk_q  <= SW'(new_brk);
						if (grow > gr_q) begin
							ins_q.start <= GW'(RW'(brk_q) + gr_q);
							ins_q.size  <= SW'(grow - gr_q);
							state_q     <= S_INS;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_INS: begin
					if (cnt_q == TABLE_FULL) begin
						status_q <= ffha_pkg::ST_FULL;
						state_q  <= S_DONE;
					end else if (cnt_q == '0) begin
						pos_q   <= '0;
						idx_q   <= cnt_q;
						state_q <= S_SH;
					end else begin
						state_q <= S_INS_H;
					end
				end
				S_INS_H: begin
					if (t_rdata.start > ins_q.start) begin
						pos_q   <= '0;
						idx_q   <= cnt_q;
						state_q <= S_SH;
					end else begin
						idx_q   <= CW'(1);
						state_q <= S_INS_RD;
					end
				end
				S_INS_RD: begin
					if (idx_q < cnt_q) begin
						state_q <= S_INS_CHK;
					end else begin
						pos_q   <= idx_q;
						idx_q   <= cnt_q;
						state_q <= S_SH;
					end
				end
				S_INS_CHK: begin
					if (t_rdata.start < ins_q.start) begin
						idx_q   <= idx_q + CW'(1);
						state_q <= S_INS_RD;
					end else begin
						pos_q   <= idx_q;
						idx_q   <= cnt_q;
						state_q <= S_SH;
					end
				end
				S_SH: begin
					if (idx_q > pos_q) begin
						state_q <= S_SH_WR;
					end else begin
						cnt_q   <= cnt_q + CW'(1);
						state_q <= S_DONE;
					end
				end
				S_SH_WR: begin
					idx_q   <= idx_q - CW'(1);
					state_q <= S_SH;
				end
				S_FREE_CHK: begin
					if (!h_rdata[ffha_pkg::HDR_W-1]) begin
						status_q <= ffha_pkg::ST_BAD_FREE;
						state_q  <= S_DONE;
					end else if (cnt_q == TABLE_FULL) begin
						status_q <= ffha_pkg::ST_FULL;
						state_q  <= S_DONE;
					end else begin
						ins_q.start <= cur_q.start;
						ins_q.size  <= h_rdata[SW-1:0];
						state_q     <= S_INS;
					end
				end
				S_CO_LD: begin
					cur_q   <= t_rdata;
					state_q <= S_CO_RD;
				end
				S_CO_RD: begin
					state_q <= (idx_q + CW'(1) < cnt_q) ? S_CO_CHK : S_DONE;
				end
				S_CO_CHK: begin
					if (merge) begin
						cur_q   <= merged;
						rk_q    <= idx_q + CW'(1);
						ret_q   <= RET_COAL;
						state_q <= S_RM;
					end else begin
						cur_q   <= t_rdata;
						idx_q   <= idx_q + CW'(1);
						state_q <= S_CO_RD;
					end
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q   <= 1'b1;
						out_status_q <= status_q;
						out_addr_q   <= addr_q;
						out_cnt_q    <= cnt_q;
						state_q      <= S_IDLE;
					end else begin
						m_tvalid_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	ffha_ram #(
		.WIDTH(ffha_pkg::HDR_W),
		.DEPTH(ffha_pkg::HEAP_GRANULES)
	) u_hdr_ram (
		.clk  (clk),
		.we   (h_we),
		.waddr(h_waddr),
		.wdata(h_wdata),
		.raddr(h_raddr),
		.rdata(h_rdata)
	);

	ffha_ram #(
		.WIDTH($bits(ffha_pkg::fent_t)),
		.DEPTH(ffha_pkg::FREE_ENTRIES)
	) u_tbl_ram (
		.clk  (clk),
		.we   (t_we),
		.waddr(t_waddr),
		.wdata(t_wdata),
		.raddr(t_raddr),
		.rdata(t_rdata)
	);

endmodule

[src/ffha_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module ffha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[src/ffha_checker.sv]
// Port-level checks of the heap allocator and their binding to the top level.
module ffha_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	// A stalled result stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// Status codes stay within the defined set.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[2:0] <= ffha_pkg::ST_FULL))
		else $error("undefined status");

	// Only a successful or table-full allocate returns an address.
	a_addr: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[21:3] != '0) |->
		(m_tdata[2:0] == ffha_pkg::ST_OK || m_tdata[2:0] == ffha_pkg::ST_FULL))
		else $error("address with failing status");

	// The table never holds more than its capacity.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[28:22] <= 7'(ffha_pkg::FREE_ENTRIES)))
		else $error("free entry count beyond capacity");

	// A request is never taken in the cycle right after another one.
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("back-to-back request accepted");

endmodule

bind first_fit_heap_allocator_top ffha_checker u_ffha_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

[tb/ffha_checker.sv]
// Checker for the heap allocator: watches both streams, predicts each result and compares it.
module ffha_scoreboard (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	input  logic        cfg_wr_en,
	input  logic [16:0] cfg_wr_data,
	output int          fails,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [2:0]  status;
		logic [18:0] addr;
		logic [6:0]  entries;
	} heap_result_t;

	bit          live_mark [ffha_pkg::HEAP_GRANULES];
	int unsigned gran_size [ffha_pkg::HEAP_GRANULES];
	int unsigned tab_start [ffha_pkg::FREE_ENTRIES];
	int unsigned tab_size [ffha_pkg::FREE_ENTRIES];
	int unsigned tab_count;
	int unsigned brk;
	int unsigned limit_gr;
	heap_result_t results_due [$];

	// Address-ordered insert; an equal start goes in front of its peers except at the head.
	function automatic bit table_put(int unsigned start, int unsigned size);
		int unsigned pos;
		if (tab_count >= ffha_pkg::FREE_ENTRIES)
			return 0;
		if (tab_count == 0 || tab_start[0] > start) begin
			pos = 0;
		end else begin
			pos = 1;
			while (pos < tab_count && tab_start[pos] < start)
				pos++;
		end
		for (int unsigned k = tab_count; k > pos; k--) begin
			tab_start[k] = tab_start[k-1];
			tab_size[k]  = tab_size[k-1];
		end
		tab_start[pos] = start;
		tab_size[pos]  = size;
		tab_count++;
		return 1;
	endfunction

	function automatic void table_drop(int unsigned pos);
		for (int unsigned k = pos; k + 1 < tab_count; k++) begin
			tab_start[k] = tab_start[k+1];
			tab_size[k]  = tab_size[k+1];
		end
		tab_count--;
	endfunction

	function automatic void mark_live(int unsigned g, int unsigned size);
		if (g < ffha_pkg::HEAP_GRANULES) begin
			live_mark[g] = 1;
			gran_size[g] = size & 17'h1FFFF;
		end
	endfunction

	function automatic logic [2:0] predict_alloc(int unsigned nbytes, output logic [18:0] addr);
		int unsigned need, gr, lim, grow, base, s, orig;
		bit ok;
		addr = '0;
		if (nbytes == 0)
			return ffha_pkg::ST_ZERO;
		need = nbytes + ffha_pkg::HEADER_BYTES;
		if (need < 2 * ffha_pkg::HEADER_BYTES)
			need = 2 * ffha_pkg::HEADER_BYTES;
		gr = (need + ffha_pkg::HEADER_BYTES - 1) / ffha_pkg::HEADER_BYTES;
		for (int unsigned i = 0; i < tab_count; i++) begin
			if (tab_size[i] >= gr) begin
				s    = tab_start[i];
				orig = tab_size[i];
				table_drop(i);
				mark_live(s, gr);
				if (orig > gr)
					void'(table_put(s + gr, orig - gr));
				addr = 19'((s + 1) * ffha_pkg::HEADER_BYTES);
				return ffha_pkg::ST_OK;
			end
		end
		lim  = (limit_gr > ffha_pkg::HEAP_GRANULES) ? ffha_pkg::HEAP_GRANULES : limit_gr;
		grow = (gr > ffha_pkg::GROW_GRANULES) ? gr : ffha_pkg::GROW_GRANULES;
		if (longint'(brk) + grow > lim)
			return ffha_pkg::ST_NOMEM;
		base = brk;
		mark_live(base, gr);
		ok = 1;
		if (grow > gr)
			ok = table_put(base + gr, grow - gr);
		brk  = base + grow;
		addr = 19'((base + 1) * ffha_pkg::HEADER_BYTES);
		return ok ? ffha_pkg::ST_OK : ffha_pkg::ST_FULL;
	endfunction

	function automatic logic [2:0] predict_free(int unsigned a);
		int unsigned g;
		if (a == 0 || (a % ffha_pkg::HEADER_BYTES) != 0)
			return ffha_pkg::ST_BAD_FREE;
		g = a / ffha_pkg::HEADER_BYTES - 1;
		if (g >= brk || g >= ffha_pkg::HEAP_GRANULES)
			return ffha_pkg::ST_BAD_FREE;
		if (!live_mark[g])
			return ffha_pkg::ST_BAD_FREE;
		if (tab_count >= ffha_pkg::FREE_ENTRIES)
			return ffha_pkg::ST_FULL;
		live_mark[g] = 0;
		void'(table_put(g, gran_size[g]));
		return ffha_pkg::ST_OK;
	endfunction

	// Overlapping or adjacent neighbors merge up to the farther of the two ends.
	function automatic void merge_table();
		int unsigned i, end0, end1;
		i = 0;
		while (i + 1 < tab_count) begin
			end0 = tab_start[i] + tab_size[i];
			end1 = tab_start[i+1] + tab_size[i+1];
			if (end0 >= tab_start[i+1]) begin
				tab_size[i] = ((end1 > end0) ? end1 : end0) - tab_start[i];
				table_drop(i + 1);
			end else begin
				i++;
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		heap_result_t want, got;
		logic [1:0] mode;
		if (!arst_n) begin
			for (int g = 0; g < ffha_pkg::HEAP_GRANULES; g++) begin
				live_mark[g] = 0;
				gran_size[g] = 0;
			end
			tab_count = 0;
			brk       = 0;
			limit_gr  = 65536;
			results_due.delete();
			fails   = 0;
			pending = 0;
		end else begin
			if (cfg_wr_en)
				limit_gr = cfg_wr_data;
			if (s_tvalid && s_tready) begin
				mode         = s_tdata[1:0];
				want.status  = ffha_pkg::ST_OK;
				want.addr    = '0;
				if (mode == ffha_pkg::MODE_ALLOC)
					want.status = predict_alloc(s_tdata[21:2], want.addr);
				else if (mode == ffha_pkg::MODE_FREE)
					want.status = predict_free(s_tdata[40:22]);
				else if (mode == ffha_pkg::MODE_COALESCE)
					merge_table();
				want.entries = 7'(tab_count);
				results_due.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				got = '{m_tdata[2:0], m_tdata[21:3], m_tdata[28:22]};
				if (results_due.size() == 0) begin
					$error("result transfer with nothing outstanding: %h", m_tdata);
					fails++;
				end else begin
					want = results_due.pop_front();
					if (got.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						fails++;
					end
					if (got.addr !== want.addr) begin
						$error("payload_address: expected %0d, got %0d", want.addr, got.addr);
						fails++;
					end
					if (got.entries !== want.entries) begin
						$error("free_entries: expected %0d, got %0d", want.entries,
							got.entries);
						fails++;
					end
				end
			end
			pending = results_due.size();
		end
	end

endmodule

[tb/tb_top.sv]
// Testbench top of the heap allocator: clock, reset, request stimulus and verdict.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 400000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        cfg_wr_en;
	logic [16:0] cfg_wr_data;
	int          fails;
	int          pending;

	int          n_sent;
	int          n_results;
	int          quiet_cycles;
	bit          idle_on;
	logic [18:0] live_q [$];

	first_fit_heap_allocator_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	ffha_scoreboard chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.fails(fails), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Payload addresses handed out are kept so that most frees hit live chunks.
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			n_results++;
			if (m_tdata[21:3] != 0)
				live_q.push_back(m_tdata[21:3]);
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		int stall;
		m_tready = 0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = idle_on ? $urandom_range(0, 8) : 0;
			if (stall > 0) begin
				m_tready = 0;
				repeat (stall) @(negedge clk);
			end
			m_tready = 1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	task automatic send_req(logic [1:0] mode, logic [19:0] nbytes, logic [18:0] faddr);
		int gap;
		gap = idle_on ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			s_tvalid = 0;
			repeat (gap) @(negedge clk);
		end
		s_tdata  = {7'b0, faddr, nbytes, mode};
		s_tvalid = 1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		n_sent++;
	endtask

	task automatic drain();
		s_tvalid = 0;
		while (pending != 0) @(negedge clk);
	endtask

	task automatic set_limit(logic [16:0] value);
		drain();
		repeat (10) @(negedge clk);
		cfg_wr_en   = 1;
		cfg_wr_data = value;
		@(negedge clk);
		cfg_wr_en = 0;
	endtask

	function automatic logic [19:0] pick_bytes();
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return 20'($urandom());
		if (r < 13)
			return 20'($urandom_range(1, 9000));
		return 20'($urandom_range(1, 120));
	endfunction

	// Mostly a live chunk; sometimes it stays listed so a later free repeats it.
	function automatic logic [18:0] pick_live();
		int idx;
		logic [18:0] a;
		if (live_q.size() == 0)
			return 19'($urandom());
		idx = $urandom_range(0, live_q.size() - 1);
		a = live_q[idx];
		if ($urandom_range(0, 9) != 0)
			live_q.delete(idx);
		return a;
	endfunction

	initial begin
		logic [16:0] limits [5];
		int burst, r;
		limits      = '{17'd1100, 17'd5000, 17'd131071, 17'd65535, 17'd65536};
		s_tvalid    = 0;
		s_tdata     = '0;
		cfg_wr_en   = 0;
		cfg_wr_data = '0;
		n_sent      = 0;
		n_results   = 0;
		quiet_cycles = 0;
		idle_on     = 1;
		arst_n      = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Tightest limit: nothing can grow.
		set_limit(17'd2);
		send_req(ffha_pkg::MODE_ALLOC, 20'd0, 19'd0);
		send_req(ffha_pkg::MODE_ALLOC, 20'd1, 19'd0);
		send_req(ffha_pkg::MODE_FREE, 20'd0, 19'd0);
		send_req(MODE_UNUSED, 20'hFFFFF, 19'h7FFFF);
		send_req(ffha_pkg::MODE_COALESCE, 20'd0, 19'd0);

		set_limit(17'd1100);
		send_req(ffha_pkg::MODE_ALLOC, 20'd1, 19'd0);
		send_req(ffha_pkg::MODE_ALLOC, 20'd8, 19'd0);
		send_req(ffha_pkg::MODE_FREE, 20'd0, 19'd8);
		send_req(ffha_pkg::MODE_FREE, 20'd0, 19'd8);
		send_req(ffha_pkg::MODE_FREE, 20'd0, 19'd12);
		send_req(ffha_pkg::MODE_FREE, 20'd0, 19'h7FFF8);
		send_req(ffha_pkg::MODE_ALLOC, 20'hFFFFF, 19'd0);
		send_req(ffha_pkg::MODE_ALLOC, 20'd8184, 19'd0);
		send_req(ffha_pkg::MODE_FREE, 20'd0, 19'd24);
		send_req(ffha_pkg::MODE_COALESCE, 20'd0, 19'd0);
		send_req(ffha_pkg::MODE_ALLOC, 20'd16, 19'd0);

		for (int ph = 0; ph < 5; ph++) begin
			set_limit(limits[ph]);
			idle_on = (ph != 2);
			while (n_sent < 16 + (ph + 1) * 107) begin
				// Allocate run, then a run of mostly frees of live chunks, now and then a merge or an unused mode.
				burst = $urandom_range(4, 40);
				for (int k = 0; k < burst; k++)
					send_req(ffha_pkg::MODE_ALLOC, pick_bytes(), 19'($urandom()));
				burst = $urandom_range(2, 30);
				for (int k = 0; k < burst; k++) begin
					r = $urandom_range(0, 99);
					if (r < 80)
						send_req(ffha_pkg::MODE_FREE, 20'($urandom()), pick_live());
					else if (r < 88)
						send_req(ffha_pkg::MODE_FREE, 20'($urandom()), 19'($urandom()));
					else if (r < 96)
						send_req(ffha_pkg::MODE_COALESCE, 20'($urandom()),
							19'($urandom()));
					else
						send_req(MODE_UNUSED, 20'($urandom()), 19'($urandom()));
				end
				if (ph == 1 && $urandom_range(0, 3) == 0)
					drain();
			end
			drain();
		end

		drain();
		repeat (50) @(negedge clk);
		$display("Sent %0d requests and checked %0d results over limits from 2 to 131071,",
			n_sent, n_results);
		$display("covering growth, splits, bad frees, merges and full-table cases.");
		if (fails == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[filelist.f]
src/ffha_pkg.sv
src/ffha_ram.sv
src/first_fit_heap_allocator_top.sv
src/ffha_checker.sv
tb/ffha_checker.sv
tb/tb_top.sv
